>>> design/wsfr_pkg.sv
`default_nettype none

package wsfr_pkg;

   localparam int BYTE_W   = 8;
   localparam int REMAIN_W = 16;
   localparam int LEN7_W   = 7;
   localparam int OPCODE_W = 4;
   localparam int MASK_N   = 4;
   localparam int POS_W    = $clog2(MASK_N);

   localparam logic [OPCODE_W-1:0] OPCODE_TEXT = 4'h1;
   localparam logic [OPCODE_W-1:0] OPCODE_PING = 4'h9;
   localparam logic [LEN7_W-1:0]   LEN_EXT16   = 7'd126;
   localparam logic [LEN7_W-1:0]   LEN_EXT64   = 7'd127;

   typedef enum logic [2:0] {
      PH_HDR1 = 3'd0,
      PH_HDR2 = 3'd1,
      PH_EXT1 = 3'd2,
      PH_EXT2 = 3'd3,
      PH_MASK = 3'd4,
      PH_DATA = 3'd5,
      PH_SKIP = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      FT_OTHER = 2'd0,
      FT_TEXT  = 2'd1,
      FT_PING  = 2'd2
   } frame_kind_type;

   typedef enum logic [1:0] {
      K_BYTE  = 2'd0,
      K_EMPTY = 2'd1,
      K_PONG  = 2'd2,
      K_ABORT = 2'd3
   } kind_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic              last;
   } result_type;

endpackage

`default_nettype wire

>>> design/wsfr_if.sv
`default_nettype none

interface wsfr_req_if;
   import wsfr_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfr_rsp_if;
   import wsfr_pkg::*;
   logic              valid;
   logic              ready;
   kind_type          kind;
   logic [BYTE_W-1:0] data;
   logic              last;
   modport source (output valid, output kind, output data, output last, input ready);
   modport sink (input valid, input kind, input data, input last, output ready);
endinterface

`default_nettype wire

>>> design/wsfr_in_stage.sv
`default_nettype none

module wsfr_in_stage (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       take,
   input  wire logic [wsfr_pkg::BYTE_W-1:0] byte_in,
   input  wire logic                       advance,
   output logic                            valid,
   output logic [wsfr_pkg::BYTE_W-1:0]     byte_out
);
   import wsfr_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= byte_in;
      end
   end

   assign valid    = valid_ff;
   assign byte_out = byte_ff;

endmodule

`default_nettype wire

>>> design/wsfr_parser.sv
`default_nettype none

module wsfr_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        fire,
   input  wire logic [wsfr_pkg::BYTE_W-1:0] rx_byte,
   output wsfr_pkg::result_type             res
);
   import wsfr_pkg::*;

   phase_type                        phase_ff, phase_in;
   frame_kind_type                   ftype_ff, ftype_in;
   logic [REMAIN_W-1:0]              remaining_ff, remaining_in;
   logic [BYTE_W-1:0]                length_high_ff, length_high_in;
   logic                             masked_ff, masked_in;
   logic [MASK_N-1:0][BYTE_W-1:0]    mask_ff, mask_in;
   logic [POS_W-1:0]                 pos_ff, pos_in;

   logic [LEN7_W-1:0]   len7;
   logic [REMAIN_W-1:0] rem_dec;
   logic                len_done;
   logic [REMAIN_W-1:0] len_val;
   logic                len_masked;

   always_comb begin
      len7           = rx_byte[LEN7_W-1:0];
      rem_dec        = remaining_ff - REMAIN_W'(1);
      phase_in       = phase_ff;
      ftype_in       = ftype_ff;
      remaining_in   = remaining_ff;
      length_high_in = length_high_ff;
      masked_in      = masked_ff;
      mask_in        = mask_ff;
      pos_in         = pos_ff;
      len_done       = 1'b0;
      len_val        = '0;
      len_masked     = masked_ff;
      res            = '{valid: 1'b0, kind: K_BYTE, data: '0, last: 1'b0};

      unique case (phase_ff)
         PH_HDR2: begin
            if (ftype_ff != FT_TEXT) begin
               if (len7 == '0) begin
                  phase_in = PH_HDR1;
                  if (ftype_ff == FT_PING) begin
                     res = '{valid: 1'b1, kind: K_PONG, data: '0, last: 1'b1};
                  end
               end else begin
                  remaining_in = REMAIN_W'(len7);
                  phase_in     = PH_SKIP;
               end
            end else begin
               masked_in  = rx_byte[BYTE_W-1];
               len_masked = rx_byte[BYTE_W-1];
               mask_in    = '0;
               if (len7 == LEN_EXT16) begin
                  phase_in = PH_EXT1;
               end else if (len7 == LEN_EXT64) begin
                  phase_in = PH_HDR1;
                  res = '{valid: 1'b1, kind: K_ABORT, data: '0, last: 1'b1};
               end else begin
                  len_done = 1'b1;
                  len_val  = REMAIN_W'(len7);
               end
            end
         end
         PH_EXT1: begin
            length_high_in = rx_byte;
            phase_in       = PH_EXT2;
         end
         PH_EXT2: begin
            len_done = 1'b1;
            len_val  = {length_high_ff, rx_byte};
         end
         PH_MASK: begin
            mask_in[pos_ff] = rx_byte;
            if (pos_ff == POS_W'(MASK_N - 1)) begin
               pos_in = '0;
               if (remaining_ff == '0) begin
                  phase_in = PH_HDR1;
                  res = '{valid: 1'b1, kind: K_EMPTY, data: '0, last: 1'b1};
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         PH_DATA: begin
            pos_in       = pos_ff + POS_W'(1);
            remaining_in = rem_dec;
            res = '{valid: 1'b1, kind: K_BYTE, data: rx_byte ^ mask_ff[pos_ff],
                    last: (rem_dec == '0)};
            if (rem_dec == '0) begin
               phase_in = PH_HDR1;
            end
         end
         PH_SKIP: begin
            remaining_in = rem_dec;
            if (rem_dec == '0) begin
               phase_in = PH_HDR1;
               if (ftype_ff == FT_PING) begin
                  res = '{valid: 1'b1, kind: K_PONG, data: '0, last: 1'b1};
               end
            end
         end
         default: begin
            if (rx_byte[OPCODE_W-1:0] == OPCODE_PING) begin
               ftype_in = FT_PING;
            end else if (rx_byte[OPCODE_W-1:0] == OPCODE_TEXT) begin
               ftype_in = FT_TEXT;
            end else begin
               ftype_in = FT_OTHER;
            end
            phase_in = PH_HDR2;
         end
      endcase

      if (len_done) begin
         remaining_in = len_val;
         pos_in       = '0;
         if (len_masked) begin
            phase_in = PH_MASK;
         end else if (len_val == '0) begin
            phase_in = PH_HDR1;
            res = '{valid: 1'b1, kind: K_EMPTY, data: '0, last: 1'b1};
         end else begin
            phase_in = PH_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR1;
         ftype_ff       <= FT_OTHER;
         remaining_ff   <= '0;
         length_high_ff <= '0;
         masked_ff      <= 1'b0;
         mask_ff        <= '0;
         pos_ff         <= '0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         ftype_ff       <= ftype_in;
         remaining_ff   <= remaining_in;
         length_high_ff <= length_high_in;
         masked_ff      <= masked_in;
         mask_ff        <= mask_in;
         pos_ff         <= pos_in;
      end
   end

   a_data_gives_byte: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_DATA |-> res.valid && res.kind == K_BYTE)
      else $error("payload byte produced no result");

   a_event_shape: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.kind != K_BYTE |-> res.last && res.data == '0)
      else $error("event result with data or without last");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remaining_ff != '0)
      else $error("payload phase with nothing remaining");

   a_mask_exit: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_MASK && pos_ff == POS_W'(MASK_N - 1)
      |=> phase_ff == PH_DATA || phase_ff == PH_HDR1)
      else $error("mask key end left to a wrong phase");

endmodule

`default_nettype wire

>>> design/wsfr_out_stage.sv
`default_nettype none

module wsfr_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wsfr_pkg::result_type      res,
   output logic                      free,
   wsfr_rsp_if.source                rsp_ch
);
   import wsfr_pkg::*;

   logic              valid_ff, valid_in;
   kind_type          kind_ff;
   logic [BYTE_W-1:0] data_ff;
   logic              last_ff;

   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= res.kind;
         data_ff <= res.data;
         last_ff <= res.last;
      end
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.kind  = kind_ff;
   assign rsp_ch.data  = data_ff;
   assign rsp_ch.last  = last_ff;

endmodule

`default_nettype wire

>>> design/websocket_frame_receiver.sv
// Channel   Dir   Payload                         Handshake
// req_ch    in    rx_byte[7:0]                    valid / ready
// rsp_ch    out   kind[1:0], data[7:0], last      valid / ready
//
// One byte per cycle sustained while rsp_ch does not stall; an accepted byte is held in the input register,
// parse logic works on it, and its result loads the result register, which drives rsp_ch directly.
// Reset is synchronous, active high, and returns the parser to the first header byte.
// A byte that gives no result moves on even while the result register is stalled;
// a byte that gives a result waits in the input register until the result register frees.
`default_nettype none

module websocket_frame_receiver (
   input  wire logic  clock,
   input  wire logic  reset,
   wsfr_req_if.sink   req_ch,
   wsfr_rsp_if.source rsp_ch
);
   import wsfr_pkg::*;

   logic              in_valid;
   logic [BYTE_W-1:0] in_byte;
   logic              advance;
   logic              out_free;
   result_type        res;

   assign advance      = in_valid && (!res.valid || out_free);
   assign req_ch.ready = !in_valid || advance;

   wsfr_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .take     (req_ch.valid && req_ch.ready),
      .byte_in  (req_ch.rx_byte),
      .advance  (advance),
      .valid    (in_valid),
      .byte_out (in_byte)
   );

   wsfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .rx_byte (in_byte),
      .res     (res)
   );

   wsfr_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && res.valid),
      .res    (res),
      .free   (out_free),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire
